// ===== sv/mvp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the matrix-vector product block.
package mvp_pkg;

    localparam int VALUE_W     = 32;
    localparam int IDX_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int MAX_N_DEF   = 64;
    localparam int CMDQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH  = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAC  = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          vec_index;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] row_result;
        logic [IDX_W-1:0]          row_index;
        logic                      last_row;
    } t_out_item;

    typedef struct packed {
        logic             is_mac;
        logic             last_col;
        logic             last_row;
        logic [IDX_W-1:0] row_index;
    } t_cmd_ctl;

endpackage

// ===== sv/mvp_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue with full, empty and fill count.
module mvp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_wdata,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [W-1:0]               o_rdata,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

endmodule

// ===== sv/mvp_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input beats, tracks row and column, issues commands.
module mvp_front #(
    parameter int MAX_N = mvp_pkg::MAX_N_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mvp_pkg::SIZE_W-1:0]           i_cfg_wdata,
    input  logic                                 i_push,
    input  mvp_pkg::t_in_item                    i_in,
    input  logic                                 i_q_full,
    output logic                                 o_full,
    output logic                                 o_cmd_push,
    output mvp_pkg::t_cmd_ctl                    o_ctl,
    output logic [$clog2(MAX_N)-1:0]             o_addr,
    output logic signed [mvp_pkg::VALUE_W-1:0]   o_value
);
    import mvp_pkg::*;

    localparam int AW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N+1);

    logic [SIZE_W-1:0] r_size;
    logic [AW-1:0]     r_col;
    logic [AW-1:0]     r_row;
    logic [AW-1:0]     n_col;
    logic [AW-1:0]     n_row;
    logic [NW-1:0]     used_n;
    logic              accept;
    logic              is_mac;
    logic              last_col;
    logic              last_row;
    logic              load_ok;

    always_comb begin
        if (r_size == '0) begin
            used_n = NW'(1);
        end else if (int'(r_size) > MAX_N) begin
            used_n = NW'(MAX_N);
        end else begin
            used_n = NW'(r_size);
        end
    end

    assign accept   = i_push && !i_q_full;
    assign is_mac   = (i_in.op == OP_MAC);
    assign last_col = ((NW'(r_col) + NW'(1)) == used_n);
    assign last_row = ((NW'(r_row) + NW'(1)) == used_n);
    assign load_ok  = (int'(i_in.vec_index) < MAX_N);

    always_comb begin
        n_col = r_col + AW'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + AW'(1);
        end
    end

    assign o_full          = i_q_full;
    assign o_cmd_push      = accept && (is_mac || load_ok);
    assign o_ctl.is_mac    = is_mac;
    assign o_ctl.last_col  = last_col;
    assign o_ctl.last_row  = last_row;
    assign o_ctl.row_index = IDX_W'(r_row);
    assign o_addr          = is_mac ? r_col : AW'(i_in.vec_index);
    assign o_value         = i_in.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
            r_col  <= '0;
            r_row  <= '0;
        end else if (accept && is_mac) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/mvp_back.sv =====
`timescale 1ns / 1ps
// Back end: vector store, multiply stage and row accumulator.
module mvp_back #(
    parameter int MAX_N     = mvp_pkg::MAX_N_DEF,
    parameter int OUT_DEPTH = mvp_pkg::OUTQ_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clear,
    input  logic                                 i_cmd_empty,
    output logic                                 o_cmd_pop,
    input  mvp_pkg::t_cmd_ctl                    i_ctl,
    input  logic [$clog2(MAX_N)-1:0]             i_addr,
    input  logic signed [mvp_pkg::VALUE_W-1:0]   i_value,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]       i_out_count,
    output logic                                 o_res_push,
    output mvp_pkg::t_out_item                   o_res
);
    import mvp_pkg::*;

    logic [VALUE_W-1:0] r_vec_mem [MAX_N];

    logic               r_s1_valid;
    t_cmd_ctl           r_s1_ctl;
    logic [VALUE_W-1:0] r_s1_value;
    logic [VALUE_W-1:0] r_s1_vec;

    logic               r_s2_valid;
    t_cmd_ctl           r_s2_ctl;
    logic [VALUE_W-1:0] r_s2_prod;

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] sum;
    logic               s1_res;
    logic               s2_res;
    logic               pop;

    assign s1_res = r_s1_valid && r_s1_ctl.last_col;
    assign s2_res = r_s2_valid && r_s2_ctl.last_col;
    assign pop    = !i_cmd_empty &&
                    ((int'(i_out_count) + int'(s1_res) + int'(s2_res)) < OUT_DEPTH);
    assign o_cmd_pop = pop;

    always_ff @(posedge i_clk) begin
        if (pop && !i_ctl.is_mac) begin
            r_vec_mem[i_addr] <= i_value;
        end
        r_s1_vec <= r_vec_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctl   <= i_ctl;
        r_s1_value <= i_value;
        r_s2_ctl   <= r_s1_ctl;
        r_s2_prod  <= VALUE_W'(r_s1_value * r_s1_vec);
    end

    assign sum              = r_acc + r_s2_prod;
    assign o_res_push       = s2_res;
    assign o_res.row_result = sum;
    assign o_res.row_index  = r_s2_ctl.row_index;
    assign o_res.last_row   = r_s2_ctl.last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_valid <= pop && i_ctl.is_mac;
            r_s2_valid <= r_s1_valid;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_s2_valid) begin
                r_acc <= r_s2_ctl.last_col ? '0 : sum;
            end
        end
    end

endmodule

// ===== sv/matrix_vector_product.sv =====
`timescale 1ns / 1ps
// Top level of the matrix-vector product block.
//
//  channel | ports                          | beat taken when
//  --------+--------------------------------+---------------------
//  input   | push, full, i_in               | push && !full
//  result  | empty, pop, o_out              | pop && !empty
//  config  | i_cfg_we, i_cfg_wdata (size_n) | i_cfg_we
//
// One input beat per cycle while full is low; a row's result reaches o_out
// after its closing beat has passed the command queue, the vector store
// read register, the multiply stage register and the result queue. Reset
// is synchronous, active low, and sets size_n to 8. When the result queue
// backs up, the command queue fills and full rises.
module matrix_vector_product #(
    parameter int MAX_N = mvp_pkg::MAX_N_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mvp_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  mvp_pkg::t_in_item          i_in,
    output logic                       empty,
    input  logic                       pop,
    output mvp_pkg::t_out_item         o_out
);
    import mvp_pkg::*;

    localparam int AW   = $clog2(MAX_N);
    localparam int CMDW = $bits(t_cmd_ctl) + AW + VALUE_W;
    localparam int OUTW = $bits(t_out_item);
    localparam int OCW  = $clog2(OUTQ_DEPTH+1);

    logic                      cmd_push;
    logic                      cmd_full;
    logic                      cmd_pop;
    logic                      cmd_empty;
    t_cmd_ctl                  f_ctl;
    logic [AW-1:0]             f_addr;
    logic signed [VALUE_W-1:0] f_value;
    logic [CMDW-1:0]           q_rdata;
    t_cmd_ctl                  q_ctl;
    logic [AW-1:0]             q_addr;
    logic signed [VALUE_W-1:0] q_value;
    logic [$clog2(CMDQ_DEPTH+1)-1:0] cmd_count;

    logic                      res_push;
    t_out_item                 res;
    logic                      out_full;
    logic [OUTW-1:0]           out_rdata;
    logic [OCW-1:0]            out_count;

    mvp_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_in        (i_in),
        .i_q_full    (cmd_full),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_ctl       (f_ctl),
        .o_addr      (f_addr),
        .o_value     (f_value)
    );

    mvp_fifo #(
        .W     (CMDW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata ({f_ctl, f_addr, f_value}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    assign {q_ctl, q_addr, q_value} = q_rdata;

    mvp_back #(
        .MAX_N     (MAX_N),
        .OUT_DEPTH (OUTQ_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_ctl       (q_ctl),
        .i_addr      (q_addr),
        .i_value     (q_value),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    mvp_fifo #(
        .W     (OUTW),
        .DEPTH (OUTQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_out = out_rdata;

    a_no_result_drop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) res_push |-> !out_full
    ) else $error("result pushed into a full result queue");

    a_no_cmd_drop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_push |-> !cmd_full
    ) else $error("command pushed into a full command queue");

    a_pop_needs_cmd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_pop |-> (cmd_count != '0)
    ) else $error("back end popped an empty command queue");

endmodule
